@@ rtl/core/spo_pkg.sv @@
package spo_pkg;

	localparam int unsigned AXES = 3;

	typedef struct packed {
		logic [AXES-1:0][31:0] pos;
		logic [AXES-1:0][31:0] d;
		logic [AXES-1:0][30:0] amag;
		logic [30:0]           comb;
		logic                  inbox;
	} meta_t;

endpackage

@@ rtl/core/sphere_push_out.sv @@
// Sphere push-out pipeline.
// Input stream s_*: one transfer per probe/sphere pair, no frame structure.
// Output stream m_*: one transfer per input, same order; m_tuser is the hit
// flag, m_tdata the owner position after the push (unchanged on a miss).
// Throughput: one pair per cycle while the output is not stalled. The path
// from input transfer to m_tvalid runs through four setup stages (delta, box
// test, squares, sum), 32 stages of a radix-4 square root, one multiply stage,
// 31 stages of a restoring divider and one output stage.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or taken, so s_tready follows m_tready while the last
// stage holds data. A stall freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits; no pipeline data is cleared.
module sphere_push_out (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, extra_radius[29:0], center_x, center_y,
	// center_z, offset_x, offset_y, offset_z, sphere_radius[29:0], 4 zero bits
	input  logic [351:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_x, new_y, new_z
	output logic [95:0]  m_tdata,
	// hit
	output logic         m_tuser
);
	import spo_pkg::*;

	localparam int unsigned RT_N = 32;
	localparam int unsigned DV_N = 31;

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: deltas and combined radius
	logic  v_s1;
	meta_t m_s1;
	logic [AXES-1:0][31:0] p_in, c_in, o_in;

	assign p_in[0] = s_tdata[31:0];
	assign p_in[1] = s_tdata[63:32];
	assign p_in[2] = s_tdata[95:64];
	assign c_in[0] = s_tdata[157:126];
	assign c_in[1] = s_tdata[189:158];
	assign c_in[2] = s_tdata[221:190];
	assign o_in[0] = s_tdata[253:222];
	assign o_in[1] = s_tdata[285:254];
	assign o_in[2] = s_tdata[317:286];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < AXES; i++) begin
				m_s1.pos[i]  <= c_in[i];
				m_s1.d[i]    <= p_in[i] - (c_in[i] + o_in[i]);
				m_s1.amag[i] <= '0;
			end
			m_s1.comb  <= {1'b0, s_tdata[125:96]} + {1'b0, s_tdata[347:318]};
			m_s1.inbox <= 1'b0;
		end
	end

	// stage 2: box prefilter and magnitudes
	logic  v_s2;
	meta_t m_s2;
	meta_t m_nx2;
	logic [AXES-1:0] in_ax;
	logic [AXES-1:0][31:0] mag;

	always_comb begin
		m_nx2 = m_s1;
		for (int i = 0; i < AXES; i++) begin
			in_ax[i] = ($signed({m_s1.d[i][31], m_s1.d[i]}) < $signed({2'b00, m_s1.comb}))
			        && ($signed({m_s1.d[i][31], m_s1.d[i]}) > -$signed({2'b00, m_s1.comb}));
			mag[i]   = m_s1.d[i][31] ? (32'd0 - m_s1.d[i]) : m_s1.d[i];
			m_nx2.amag[i] = mag[i][30:0];
		end
		m_nx2.inbox = &in_ax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2 <= m_nx2;
		end
	end

	// stage 3: squares
	logic  v_s3;
	meta_t m_s3;
	logic [AXES-1:0][61:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3 <= m_s2;
			for (int i = 0; i < AXES; i++) begin
				sq_s3[i] <= 62'(m_s2.amag[i]) * 62'(m_s2.amag[i]);
			end
		end
	end

	// stage 4: sum of squares
	logic        v_s4;
	meta_t       m_s4;
	logic [63:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s4   <= m_s3;
			sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
		end
	end

	// square root, two radicand bits per stage
	logic        rt_v_s5 [RT_N];
	meta_t       rt_m_s5 [RT_N];
	logic [63:0] rt_n_s5 [RT_N];
	logic [33:0] rt_r_s5 [RT_N];
	logic [31:0] rt_q_s5 [RT_N];

	genvar j;
	generate
		for (j = 0; j < RT_N; j++) begin : g_rt
			logic        v_in;
			meta_t       m_in;
			logic [63:0] n_in;
			logic [33:0] r_in;
			logic [31:0] q_in;
			logic [35:0] a, t;
			logic        ge;

			if (j == 0) begin : g_first
				assign v_in = v_s4;
				assign m_in = m_s4;
				assign n_in = sum_s4;
				assign r_in = '0;
				assign q_in = '0;
			end else begin : g_next
				assign v_in = rt_v_s5[j-1];
				assign m_in = rt_m_s5[j-1];
				assign n_in = rt_n_s5[j-1];
				assign r_in = rt_r_s5[j-1];
				assign q_in = rt_q_s5[j-1];
			end

			assign a  = {r_in, n_in[63:62]};
			assign t  = {2'b00, q_in, 2'b01};
			assign ge = a >= t;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rt_v_s5[j] <= 1'b0;
				end else if (adv) begin
					rt_v_s5[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rt_m_s5[j] <= m_in;
					rt_n_s5[j] <= {n_in[61:0], 2'b00};
					rt_r_s5[j] <= ge ? 34'(a - t) : a[33:0];
					rt_q_s5[j] <= {q_in[30:0], ge};
				end
			end
		end
	endgenerate

	// stage 6: overlap test, divisor clamp, products
	logic        v_s6;
	meta_t       m_s6;
	logic        hit_s6;
	logic [30:0] div_s6;
	logic [AXES-1:0][61:0] prod_s6;
	logic [31:0] rt_root;

	assign rt_root = rt_q_s5[RT_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= rt_v_s5[RT_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6   <= rt_m_s5[RT_N-1];
			hit_s6 <= rt_m_s5[RT_N-1].inbox && (rt_root < {1'b0, rt_m_s5[RT_N-1].comb});
			div_s6 <= (rt_root == 32'd0) ? 31'd1 : rt_root[30:0];
			for (int i = 0; i < AXES; i++) begin
				prod_s6[i] <= 62'(rt_m_s5[RT_N-1].amag[i]) * 62'(rt_m_s5[RT_N-1].comb);
			end
		end
	end

	// restoring divider, one quotient bit per stage
	logic        dv_v_s7   [DV_N];
	meta_t       dv_m_s7   [DV_N];
	logic        dv_hit_s7 [DV_N];
	logic [30:0] dv_div_s7 [DV_N];
	logic [AXES-1:0][61:0] dv_rem_s7 [DV_N];
	logic [AXES-1:0][30:0] dv_q_s7   [DV_N];

	genvar k;
	generate
		for (k = 0; k < DV_N; k++) begin : g_dv
			localparam int unsigned SH = DV_N - 1 - k;
			logic        v_in;
			meta_t       m_in;
			logic        hit_in;
			logic [30:0] div_in;
			logic [AXES-1:0][61:0] rem_in;
			logic [AXES-1:0][30:0] q_in;
			logic [61:0] dsh;
			logic [AXES-1:0] ge;

			if (k == 0) begin : g_first
				assign v_in   = v_s6;
				assign m_in   = m_s6;
				assign hit_in = hit_s6;
				assign div_in = div_s6;
				assign rem_in = prod_s6;
				assign q_in   = '0;
			end else begin : g_next
				assign v_in   = dv_v_s7[k-1];
				assign m_in   = dv_m_s7[k-1];
				assign hit_in = dv_hit_s7[k-1];
				assign div_in = dv_div_s7[k-1];
				assign rem_in = dv_rem_s7[k-1];
				assign q_in   = dv_q_s7[k-1];
			end

			assign dsh = 62'(div_in) << SH;

			always_comb begin
				for (int i = 0; i < AXES; i++) begin
					ge[i] = rem_in[i] >= dsh;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s7[k] <= 1'b0;
				end else if (adv) begin
					dv_v_s7[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_m_s7[k]   <= m_in;
					dv_hit_s7[k] <= hit_in;
					dv_div_s7[k] <= div_in;
					for (int i = 0; i < AXES; i++) begin
						dv_rem_s7[k][i] <= ge[i] ? (rem_in[i] - dsh) : rem_in[i];
						dv_q_s7[k][i]   <= {q_in[i][29:0], ge[i]};
					end
				end
			end
		end
	endgenerate

	// stage 8: signed quotient, push and new position
	logic        v_s8;
	logic        hit_s8;
	logic [AXES-1:0][31:0] new_s8;
	logic [AXES-1:0][31:0] qs;
	meta_t       mf;

	assign mf = dv_m_s7[DV_N-1];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			qs[i] = mf.d[i][31] ? (32'd0 - {1'b0, dv_q_s7[DV_N-1][i]})
			                    : {1'b0, dv_q_s7[DV_N-1][i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= dv_v_s7[DV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s8 <= dv_hit_s7[DV_N-1];
			for (int i = 0; i < AXES; i++) begin
				new_s8[i] <= dv_hit_s7[DV_N-1] ? (mf.pos[i] - qs[i] + mf.d[i]) : mf.pos[i];
			end
		end
	end

	assign m_tvalid = v_s8;
	assign m_tuser  = hit_s8;
	assign m_tdata  = {new_s8[2], new_s8[1], new_s8[0]};

endmodule

@@ verif/sphere_push_out_chk.sv @@
`timescale 1ns / 100ps

module sphere_push_out_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [351:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic        hit;
		logic [31:0] nz;
		logic [31:0] ny;
		logic [31:0] nx;
	} push_res_t;

	push_res_t res_q[$];

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem, root, b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic push_res_t push_out(input logic [351:0] t);
		logic [31:0] pos[3];
		logic signed [63:0] d[3];
		logic signed [63:0] comb, dst, q, push;
		logic [63:0] sumsq, a;
		logic [31:0] p, c, o, cen;
		logic inbox;
		push_res_t r;
		comb = $signed({34'd0, t[125:96]}) + $signed({34'd0, t[347:318]});
		inbox = 1;
		for (int i = 0; i < 3; i++) begin
			p = t[32*i +: 32];
			c = t[126 + 32*i +: 32];
			o = t[222 + 32*i +: 32];
			cen = c + o;
			pos[i] = c;
			d[i] = $signed(p - cen);
			if (!(-comb < d[i] && d[i] < comb))
				inbox = 0;
		end
		r.hit = 0;
		if (inbox) begin
			sumsq = 0;
			for (int i = 0; i < 3; i++) begin
				a = d[i] < 0 ? -d[i] : d[i];
				sumsq = sumsq + a * a;
			end
			dst = $signed(isqrt64(sumsq));
			if (dst < comb) begin
				if (dst == 0)
					dst = 1;
				for (int i = 0; i < 3; i++) begin
					q = (d[i] * comb) / dst;
					push = q - d[i];
					pos[i] = pos[i] - push[31:0];
				end
				r.hit = 1;
			end
		end
		r.nx = pos[0];
		r.ny = pos[1];
		r.nz = pos[2];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending = res_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		push_res_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				res_q.push_back(push_out(s_tdata));
			if (m_tvalid && m_tready) begin
				if (res_q.size() == 0) begin
					report("unexpected transfer", 32'd1, 32'd0);
				end else begin
					e = res_q.pop_front();
					if (m_tuser !== e.hit)
						report("hit", {31'd0, m_tuser}, {31'd0, e.hit});
					if (m_tdata[31:0] !== e.nx)
						report("new_x", m_tdata[31:0], e.nx);
					if (m_tdata[63:32] !== e.ny)
						report("new_y", m_tdata[63:32], e.ny);
					if (m_tdata[95:64] !== e.nz)
						report("new_z", m_tdata[95:64], e.nz);
				end
			end
		end
	end

endmodule

@@ verif/sphere_push_out_tb.sv @@
`timescale 1ns / 100ps

module sphere_push_out_tb;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [351:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	int           fail_count;
	int           pending;
	int           src_idle_pct;
	int           snk_idle_pct;

	sphere_push_out dut (.*);

	sphere_push_out_chk chk (.*);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#8_000_000;
		$display("sphere_push_out regression: fail");
		$finish;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	function automatic logic [351:0] pack_pair(
		input logic [31:0] px, py, pz, input logic [29:0] er,
		input logic [31:0] cx, cy, cz, ox, oy, oz, input logic [29:0] sr);
		return {4'd0, sr, oz, oy, ox, cz, cy, cx, er, pz, py, px};
	endfunction

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	task automatic send(input logic [351:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// random pair near the sphere so hits and near-misses both occur
	function automatic logic [351:0] near_pair();
		logic [29:0] er, sr;
		logic [31:0] cx, cy, cz, ox, oy, oz;
		logic [31:0] dx, dy, dz;
		int span;
		int sh;
		sh = $urandom_range(29);
		er = $urandom() >> (2 + $urandom_range(29));
		sr = $urandom() >> (2 + sh);
		span = ({2'b0, er} + sr) >> $urandom_range(1);
		cx = rnd32(); cy = rnd32(); cz = rnd32();
		ox = rnd32(); oy = rnd32(); oz = rnd32();
		dx = $signed($urandom_range(2 * span + 2)) - span - 1;
		dy = $signed($urandom_range(2 * span + 2)) - span - 1;
		dz = $signed($urandom_range(2 * span + 2)) - span - 1;
		return pack_pair(cx + ox + dx, cy + oy + dy, cz + oz + dz, er,
			cx, cy, cz, ox, oy, oz, sr);
	endfunction

	initial begin
		logic [31:0] mx, mn;
		logic [29:0] rmax;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		rmax = '1;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		src_idle_pct = 18;
		snk_idle_pct = 71;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// coincident centres, zero radius miss, extremes, wrapping sums
		send(pack_pair(0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 7));
		send(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(pack_pair(mx, mx, mx, rmax, mx, mx, mx, 0, 0, 0, rmax));
		send(pack_pair(mn, mn, mn, rmax, mx, mx, mx, 1, 1, 1, rmax));
		send(pack_pair(mx, mn, 0, rmax, mn, mx, 0, mx, mn, 0, rmax));
		send(pack_pair(100, 0, 0, 50, 0, 0, 0, 0, 0, 0, 50));
		send(pack_pair(99, 0, 0, 50, 0, 0, 0, 0, 0, 0, 50));
		send(pack_pair(1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1));
		send(pack_pair(-3, 2, -1, 0, 0, 0, 0, 0, 0, 0, 4));
		send(pack_pair(rmax, rmax, rmax, rmax, 0, 0, 0, 0, 0, 0, rmax));
		send(pack_pair(1, 0, 0, rmax, 0, 0, 0, 0, 0, 0, rmax));
		send(pack_pair(-1, -1, 0, rmax, 0, 0, 0, 0, 0, 0, 0));
		send(pack_pair(mn, 0, 0, rmax, 0, 0, 0, 0, 0, 0, rmax));
		send(pack_pair(5, 5, 5, 0, 5, 5, 5, 0, 0, 0, 0));
		send(pack_pair('1, '1, '1, rmax, '1, '1, '1, '1, '1, '1, rmax));
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = ph == 0 ? 18 : ph == 1 ? 71 : 0;
			snk_idle_pct = ph == 0 ? 71 : ph == 1 ? 18 : 0;
			for (int i = 0; i < 610; i++) begin
				if ($urandom_range(9) < 8)
					send(near_pair());
				else
					send(pack_pair(rnd32(), rnd32(), rnd32(), $urandom(),
						rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
						$urandom()));
			end
		end
		s_tvalid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("sphere_push_out regression: pass");
		else
			$display("sphere_push_out regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/spo_pkg.sv
rtl/core/sphere_push_out.sv
verif/sphere_push_out_chk.sv
verif/sphere_push_out_tb.sv
